FILE: rtl/core/call_stack_time_profiler_defines.svh
// Assertion macros for the call stack time profiler.
// Used by call_stack_time_profiler.sv; expects i_clk and i_rst_n in scope.
`ifndef CALL_STACK_TIME_PROFILER_DEFINES_SVH
`define CALL_STACK_TIME_PROFILER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CSTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CSTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/cstp_pkg.sv
// Shared types and constants of the call stack time profiler.
// No dependencies; used by cstp_frame_stack and call_stack_time_profiler.
package cstp_pkg;

    localparam int FUNCTION_COUNT = 4096;  // power of two: slot is the low id bits
    localparam int STACK_DEPTH    = 256;

    localparam int ID_W    = 12;
    localparam int TS_W    = 64;
    localparam int DEPTH_W = 9;
    localparam int FN_AW   = $clog2(FUNCTION_COUNT);
    localparam int FR_AW   = $clog2(STACK_DEPTH);
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);

    localparam logic [SP_W-1:0]    SP_FULL    = SP_W'(STACK_DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);

    localparam logic [1:0] OP_ENTER = 2'd0;
    localparam logic [1:0] OP_LEAVE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;  // decoded as a read

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DISABLED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [1:0]      operation;
        logic [ID_W-1:0] function_id;
        logic [TS_W-1:0] timestamp;
    } t_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    record_id;
        logic [TS_W-1:0]    call_count;
        logic [TS_W-1:0]    inclusive_time;
        logic [TS_W-1:0]    exclusive_time;
        logic [DEPTH_W-1:0] depth;
    } t_result;

    typedef struct packed {
        logic [TS_W-1:0] calls;
        logic [TS_W-1:0] incl;
        logic [TS_W-1:0] excl;
    } t_record;

    typedef struct packed {
        logic [ID_W-1:0] func;
        logic [TS_W-1:0] start;
        logic [TS_W-1:0] child;
    } t_frame;

    // request to the frame stack, applied at the clock edge
    typedef struct packed {
        logic            push;
        logic            pop;
        logic [ID_W-1:0] id;
        logic [TS_W-1:0] start;
        logic [TS_W-1:0] elapsed;
    } t_stack_cmd;

    typedef struct packed {
        t_frame          frame;
        logic [SP_W-1:0] sp;
    } t_stack_top;

endpackage

FILE: rtl/core/cstp_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No package dependency.
module cstp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/cstp_frame_stack.sv
// Call frame stack: top frame held in registers, lower frames in a RAM.
// Depends on cstp_pkg and cstp_ram.
module cstp_frame_stack (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  cstp_pkg::t_stack_cmd  i_cmd,
    output cstp_pkg::t_stack_top  o_top
);

    logic [cstp_pkg::SP_W-1:0]  r_sp;
    cstp_pkg::t_frame           r_top;
    cstp_pkg::t_frame           rd_frame;
    logic [cstp_pkg::SP_W-1:0]  sp_m1;
    logic [cstp_pkg::SP_W-1:0]  sp_m2;
    logic                       spill;

    assign sp_m1 = r_sp - cstp_pkg::SP_W'(1);
    assign sp_m2 = r_sp - cstp_pkg::SP_W'(2);
    // pushing onto a non-empty stack moves the cached top down into RAM
    assign spill = i_cmd.push && (r_sp != '0);

    cstp_ram #(
        .WIDTH ($bits(cstp_pkg::t_frame)),
        .DEPTH (cstp_pkg::STACK_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (spill),
        .i_waddr (sp_m1[cstp_pkg::FR_AW-1:0]),
        .i_wdata (r_top),
        .i_re    (i_rd_en),
        .i_raddr (sp_m2[cstp_pkg::FR_AW-1:0]),  // frame below the top
        .o_rdata (rd_frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_cmd.push) begin
            r_sp <= r_sp + cstp_pkg::SP_W'(1);
        end else if (i_cmd.pop) begin
            r_sp <= sp_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top.func  <= i_cmd.id;
            r_top.start <= i_cmd.start;
            r_top.child <= '0;
        end else if (i_cmd.pop && (r_sp >= cstp_pkg::SP_W'(2))) begin
            r_top.func  <= rd_frame.func;
            r_top.start <= rd_frame.start;
            r_top.child <= rd_frame.child + i_cmd.elapsed;
        end
    end

    assign o_top.frame = r_top;
    assign o_top.sp    = r_sp;

endmodule

FILE: rtl/core/call_stack_time_profiler.sv
// Call stack time profiler: a new request is taken only once the last has executed;
// execution waits for a free output register and registers the result (held while the
// sink stalls). Each request is one read of the record RAM and frame RAM at acceptance,
// then modify and write back at execution. Reset: synchronous; afterwards the record RAM
// is zeroed one entry per cycle (all FUNCTION_COUNT entries) with o_in_ready low; config writes are taken.
// Depends on cstp_pkg, cstp_ram, cstp_frame_stack, call_stack_time_profiler_defines.svh.
`include "call_stack_time_profiler_defines.svh"

module call_stack_time_profiler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cstp_pkg::t_item   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cstp_pkg::t_result o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data
);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} t_state;

    t_state                       r_state;
    logic [cstp_pkg::FN_AW-1:0]   r_clr_addr;
    logic                         r_enable;
    logic                         r_out_valid;
    cstp_pkg::t_result            r_out;
    cstp_pkg::t_item              r_item;
    logic [cstp_pkg::TS_W-1:0]    r_elapsed;
    logic [cstp_pkg::TS_W-1:0]    r_self;

    cstp_pkg::t_stack_top         top;
    cstp_pkg::t_stack_cmd         stack_cmd;
    cstp_pkg::t_record            rd_rec;
    cstp_pkg::t_record            n_rec;
    cstp_pkg::t_result            n_out;
    logic                         accept;
    logic                         exec_fire;
    logic                         push_c;
    logic                         pop_c;
    logic                         wr_c;
    logic                         report;
    logic [1:0]                   status;
    logic [cstp_pkg::ID_W-1:0]    rid;
    logic [cstp_pkg::SP_W-1:0]    sp_after;
    logic [cstp_pkg::ID_W-1:0]    rd_id;
    logic [cstp_pkg::TS_W-1:0]    elapsed_in;
    logic                         rec_we;
    logic [cstp_pkg::FN_AW-1:0]   rec_waddr;
    cstp_pkg::t_record            rec_wdata;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign exec_fire   = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // a leave addresses the record of the function on top of the stack
    assign rd_id      = (i_in_data.operation == cstp_pkg::OP_LEAVE) ?
                        top.frame.func : i_in_data.function_id;
    assign elapsed_in = i_in_data.timestamp - top.frame.start;

    assign rec_we    = (r_state == S_CLEAR) || (exec_fire && wr_c);
    assign rec_waddr = (r_state == S_CLEAR) ? r_clr_addr : rid[cstp_pkg::FN_AW-1:0];
    assign rec_wdata = (r_state == S_CLEAR) ? '0 : n_rec;

    cstp_ram #(
        .WIDTH ($bits(cstp_pkg::t_record)),
        .DEPTH (cstp_pkg::FUNCTION_COUNT)
    ) u_record_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (rec_waddr),
        .i_wdata (rec_wdata),
        .i_re    (accept),
        .i_raddr (rd_id[cstp_pkg::FN_AW-1:0]),
        .o_rdata (rd_rec)
    );

    assign stack_cmd.push    = exec_fire && push_c;
    assign stack_cmd.pop     = exec_fire && pop_c;
    assign stack_cmd.id      = r_item.function_id;
    assign stack_cmd.start   = r_item.timestamp;
    assign stack_cmd.elapsed = r_elapsed;

    cstp_frame_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (accept),
        .i_cmd   (stack_cmd),
        .o_top   (top)
    );

    always_comb begin
        n_rec  = rd_rec;
        push_c = 1'b0;
        pop_c  = 1'b0;
        wr_c   = 1'b0;
        report = 1'b1;
        status = cstp_pkg::ST_OK;
        rid    = r_item.function_id;
        case (r_item.operation)
            cstp_pkg::OP_ENTER: begin
                if (!r_enable) begin
                    status = cstp_pkg::ST_DISABLED;
                end else if (top.sp == cstp_pkg::SP_FULL) begin
                    status = cstp_pkg::ST_FULL;
                end else begin
                    push_c      = 1'b1;
                    wr_c        = 1'b1;
                    n_rec.calls = rd_rec.calls + cstp_pkg::TS_W'(1);
                end
            end
            cstp_pkg::OP_LEAVE: begin
                if (!r_enable) begin
                    status = cstp_pkg::ST_DISABLED;
                    report = 1'b0;
                end else if (top.sp == '0) begin
                    status = cstp_pkg::ST_EMPTY;
                    report = 1'b0;
                end else begin
                    pop_c      = 1'b1;
                    wr_c       = 1'b1;
                    rid        = top.frame.func;
                    n_rec.incl = rd_rec.incl + r_elapsed;
                    n_rec.excl = rd_rec.excl + r_self;
                end
            end
            default: begin
                // read, and the unused fourth code behaves as a read
            end
        endcase
        sp_after = top.sp + cstp_pkg::SP_W'(push_c) - cstp_pkg::SP_W'(pop_c);

        n_out.status         = status;
        n_out.record_id      = report ? rid : '0;
        n_out.call_count     = report ? n_rec.calls : '0;
        n_out.inclusive_time = report ? n_rec.incl : '0;
        n_out.exclusive_time = report ? n_rec.excl : '0;
        n_out.depth          = cstp_pkg::DEPTH_W'(sp_after);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_enable    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_enable <= i_cfg_data;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + cstp_pkg::FN_AW'(1);
                    if (r_clr_addr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (exec_fire) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item    <= i_in_data;
            r_elapsed <= elapsed_in;
            r_self    <= elapsed_in - top.frame.child;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `CSTP_ASSERT_NEXT(a_one_in_flight, accept, !o_in_ready, "request accepted while one in flight")
    `CSTP_ASSERT_NOW(a_full_depth, o_out_valid && (o_out_data.status == cstp_pkg::ST_FULL), (o_out_data.depth == cstp_pkg::DEPTH_FULL), "dropped enter without full stack")
    `CSTP_ASSERT_NOW(a_empty_leave, o_out_valid && (o_out_data.status == cstp_pkg::ST_EMPTY), (o_out_data.depth == '0) && (o_out_data.record_id == '0) && (o_out_data.call_count == '0), "empty-stack leave reports data")
    `CSTP_ASSERT_NOW(a_no_write_idle, (r_state == S_IDLE), !rec_we, "record write outside clear or execute")

endmodule
